FILE: rtl/line_frame_accumulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line frame accumulator
// Clocked on clk and disabled during rst. The macros expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_FRAME_ACCUMULATOR_ASSERT_SVH
`define LINE_FRAME_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFA_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFA_ASSERT_IMPLIES(label, ante, cons, msg)
`define LFA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/lfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared types and constants for the line frame accumulator.
// ----------------------------------------------------------------------------
package lfa_pkg;

  // line store geometry
  localparam int FRAME_CAPACITY = 64;
  localparam int ADDR_W         = $clog2(FRAME_CAPACITY);
  localparam int CNT_W          = ADDR_W;

  // prefix compare
  localparam int PREFIX_BYTES = 8;
  localparam int PFX_IDX_W    = $clog2(PREFIX_BYTES);

  // configuration port
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  // register indexes (byte address / 8)
  localparam logic [2:0] REG_QUERY_PREFIX     = 3'd0;
  localparam logic [2:0] REG_QUERY_PREFIX_LEN = 3'd1;
  localparam logic [2:0] REG_SYNC_PREFIX      = 3'd2;
  localparam logic [2:0] REG_SYNC_PREFIX_LEN  = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_TICKS    = 3'd4;

  // register reset values
  localparam logic [63:0] QUERY_PREFIX_RST     = 64'd250086510672;
  localparam logic [3:0]  QUERY_PREFIX_LEN_RST = 4'd5;
  localparam logic [63:0] SYNC_PREFIX_RST      = 64'd64022180483152;
  localparam logic [3:0]  SYNC_PREFIX_LEN_RST  = 4'd6;
  localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd50;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // frame classes
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_SYNC  = 2'd2;

  // special bytes
  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] frame_kind;
    logic [5:0] frame_length;
    logic       last_flag;
  } out_t;

  typedef struct packed {
    logic [63:0] query_prefix;
    logic [3:0]  query_prefix_length;
    logic [63:0] sync_prefix;
    logic [3:0]  sync_prefix_length;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // one compare step towards the prefix matchers
  typedef struct packed {
    logic                 valid;
    logic [PFX_IDX_W-1:0] idx;
    logic                 in_frame;
    logic [7:0]           data;
  } cmp_step_t;

endpackage

FILE: rtl/line_frame_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_frame_accumulator
// Collects received bytes into lines and emits each closed frame byte by
// byte with its class, length and a last marker.
//
// Input channel (in_valid/in_stall/in_data): one transaction is either a
// received byte or one time tick. A line feed closes the frame (a carriage
// return just before it is dropped); a non-empty frame also closes after
// timeout_ticks ticks without a byte. Bytes past capacity minus one are lost.
// Output channel (out_valid/out_stall/out_data): one transaction per frame
// byte, in order, kind and length repeated on each, last_flag on the final.
// A byte or tick that does not close a frame leaves in_stall low.
// A closing transaction holds in_stall through classify (one line store
// read per prefix position) and emit (one store read per frame byte),
// as the line store has a single read port; out_stall lengthens emit.
// The first frame byte is read from the store once emit is entered.
// Reset (rst, synchronous) empties the frame and restores the register
// defaults; the line store itself needs no clearing.
// Configuration: APB-style, 64-bit registers at byte addresses 8*i.
// ----------------------------------------------------------------------------
module line_frame_accumulator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lfa_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lfa_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfa_pkg::PADDR_W-1:0] paddr,
  input  logic [lfa_pkg::PDATA_W-1:0] pwdata,
  output logic [lfa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lfa_pkg::*;

`include "line_frame_accumulator_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLASS = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(FRAME_CAPACITY - 1);

  state_t           state, state_next;
  cfg_t             cfg;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [15:0]      idle_ticks, idle_ticks_next;
  logic [15:0]      idle_inc;
  logic [7:0]       last_byte, last_byte_next;
  logic [CNT_W-1:0] frame_len, frame_len_next;
  logic [CNT_W-1:0] close_len;
  logic [PFX_IDX_W:0] cls_idx, cls_idx_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             out_valid_next;
  logic             last_q, last_q_next;
  logic             cmp_clear;
  cmp_step_t        cmp_step;
  logic             cmp_valid, cmp_valid_next;
  logic [PFX_IDX_W-1:0] cmp_idx, cmp_idx_next;
  logic             cmp_in_frame, cmp_in_frame_next;
  logic             query_match, sync_match;
  logic [1:0]       kind;
  logic             in_fire;
  logic             advance;
  logic             strip_cr;

  // store ports
  logic             ram_we;
  logic             ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  lfa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfa_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_CAPACITY)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(fill_count)),
    .wdata (in_data.rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lfa_prefix_cmp u_query_cmp (
    .clk           (clk),
    .rst           (rst),
    .clear         (cmp_clear),
    .step          (cmp_step),
    .prefix        (cfg.query_prefix),
    .prefix_length (cfg.query_prefix_length),
    .match         (query_match)
  );

  lfa_prefix_cmp u_sync_cmp (
    .clk           (clk),
    .rst           (rst),
    .clear         (cmp_clear),
    .step          (cmp_step),
    .prefix        (cfg.sync_prefix),
    .prefix_length (cfg.sync_prefix_length),
    .match         (sync_match)
  );

  // handshake
  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign advance  = !out_valid || !out_stall;

  assign idle_inc  = (idle_ticks != 16'hFFFF) ? idle_ticks + 16'd1 : idle_ticks;
  assign strip_cr  = (fill_count != '0) && (last_byte == CR_BYTE);
  assign close_len = strip_cr ? fill_count - CNT_W'(1) : fill_count;

  // frame class, stable once classify is over
  always_comb begin
    if (query_match) begin
      kind = KIND_QUERY;
    end else if (sync_match) begin
      kind = KIND_SYNC;
    end else begin
      kind = KIND_TOKEN;
    end
  end

  // sequencer: accumulate, classify, emit
  always_comb begin
    state_next        = state;
    fill_count_next   = fill_count;
    idle_ticks_next   = idle_ticks;
    last_byte_next    = last_byte;
    frame_len_next    = frame_len;
    cls_idx_next      = cls_idx;
    rd_idx_next       = rd_idx;
    out_valid_next    = out_valid;
    last_q_next       = last_q;
    cmp_clear         = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_raddr         = ADDR_W'(rd_idx);
    cmp_valid_next    = 1'b0;
    cmp_idx_next      = '0;
    cmp_in_frame_next = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.func == FUNC_TICK) begin
            if (fill_count != '0) begin
              idle_ticks_next = idle_inc;
              if (idle_inc >= cfg.timeout_ticks) begin
                frame_len_next  = fill_count;
                fill_count_next = '0;
                idle_ticks_next = '0;
                cls_idx_next    = '0;
                cmp_clear       = 1'b1;
                state_next      = ST_CLASS;
              end
            end
          end else begin
            idle_ticks_next = '0;
            if (in_data.rx_byte == LF_BYTE) begin
              fill_count_next = '0;
              if (close_len != '0) begin
                frame_len_next = close_len;
                cls_idx_next   = '0;
                cmp_clear      = 1'b1;
                state_next     = ST_CLASS;
              end
            end else if (fill_count < FILL_MAX) begin
              ram_we          = 1'b1;
              fill_count_next = fill_count + CNT_W'(1);
              last_byte_next  = in_data.rx_byte;
            end
          end
        end
      end

      ST_CLASS: begin
        // read prefix positions; the compare follows in the next cycle, on the registered read data
        if (!cls_idx[PFX_IDX_W]) begin
          ram_re            = 1'b1;
          ram_raddr         = ADDR_W'(cls_idx[PFX_IDX_W-1:0]);
          cmp_valid_next    = 1'b1;
          cmp_idx_next      = cls_idx[PFX_IDX_W-1:0];
          cmp_in_frame_next = 32'(cls_idx[PFX_IDX_W-1:0]) < 32'(frame_len);
          cls_idx_next      = cls_idx + (PFX_IDX_W+1)'(1);
        end else begin
          rd_idx_next = '0;
          state_next  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // one store read per accepted output transaction
        if (advance) begin
          if (rd_idx != frame_len) begin
            ram_re         = 1'b1;
            ram_raddr      = ADDR_W'(rd_idx);
            out_valid_next = 1'b1;
            last_q_next    = (rd_idx == frame_len - CNT_W'(1));
            rd_idx_next    = rd_idx + CNT_W'(1);
          end else begin
            out_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      idle_ticks <= '0;
      cls_idx    <= '0;
      rd_idx     <= '0;
      out_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      idle_ticks <= idle_ticks_next;
      cls_idx    <= cls_idx_next;
      rd_idx     <= rd_idx_next;
      out_valid  <= out_valid_next;
      cmp_valid  <= cmp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_byte    <= last_byte_next;
    frame_len    <= frame_len_next;
    last_q       <= last_q_next;
    cmp_idx      <= cmp_idx_next;
    cmp_in_frame <= cmp_in_frame_next;
  end

  // compare data comes straight from the store read register
  assign cmp_step = {cmp_valid, cmp_idx, cmp_in_frame, ram_rdata};

  // output transaction
  assign out_data.data_byte    = ram_rdata;
  assign out_data.frame_kind   = kind;
  assign out_data.frame_length = 6'(frame_len);
  assign out_data.last_flag    = last_q;

  `LFA_ASSERT_IMPLIES(a_idle_no_output, !in_stall, !out_valid,
                      "output valid while accepting input")
  `LFA_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_count <= FILL_MAX,
                      "line store fill beyond capacity")
  `LFA_ASSERT_NEXT(a_frame_ends, out_valid && out_data.last_flag && !out_stall,
                   !out_valid, "output continues after last byte")
  `LFA_ASSERT_NEXT(a_frame_continues, out_valid && !out_data.last_flag && !out_stall,
                   out_valid, "gap inside a frame")

endmodule

FILE: rtl/lfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module lfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lfa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfa_cfg_regs
// APB-style register bank: prefixes, prefix lengths and idle timeout.
// ----------------------------------------------------------------------------
module lfa_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfa_pkg::PADDR_W-1:0] paddr,
  input  logic [lfa_pkg::PDATA_W-1:0] pwdata,
  output logic [lfa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output lfa_pkg::cfg_t               cfg
);
  import lfa_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_prefix        <= QUERY_PREFIX_RST;
      cfg.query_prefix_length <= QUERY_PREFIX_LEN_RST;
      cfg.sync_prefix         <= SYNC_PREFIX_RST;
      cfg.sync_prefix_length  <= SYNC_PREFIX_LEN_RST;
      cfg.timeout_ticks       <= TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUERY_PREFIX:     cfg.query_prefix        <= pwdata;
        REG_QUERY_PREFIX_LEN: cfg.query_prefix_length <= pwdata[3:0];
        REG_SYNC_PREFIX:      cfg.sync_prefix         <= pwdata;
        REG_SYNC_PREFIX_LEN:  cfg.sync_prefix_length  <= pwdata[3:0];
        REG_TIMEOUT_TICKS:    cfg.timeout_ticks       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    unique case (reg_idx)
      REG_QUERY_PREFIX:     prdata = cfg.query_prefix;
      REG_QUERY_PREFIX_LEN: prdata = 64'(cfg.query_prefix_length);
      REG_SYNC_PREFIX:      prdata = cfg.sync_prefix;
      REG_SYNC_PREFIX_LEN:  prdata = 64'(cfg.sync_prefix_length);
      REG_TIMEOUT_TICKS:    prdata = 64'(cfg.timeout_ticks);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/lfa_prefix_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfa_prefix_cmp
// Byte-serial prefix matcher with zero-terminated string semantics.
// Takes one frame byte per step; the verdict settles on the first
// mismatch, on a shared zero byte, or on the position past the frame.
// ----------------------------------------------------------------------------
module lfa_prefix_cmp (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  lfa_pkg::cmp_step_t step,
  input  logic [63:0]        prefix,
  input  logic [3:0]         prefix_length,
  output logic               match
);
  import lfa_pkg::*;

  logic       done;
  logic       result;
  logic [3:0] eff_len;
  logic [7:0] a_byte;
  logic [7:0] b_byte;
  logic       in_range;

  // lengths above the prefix width clamp to it
  assign eff_len  = (prefix_length > 4'(PREFIX_BYTES)) ? 4'(PREFIX_BYTES) : prefix_length;
  assign in_range = ({1'b0, step.idx} < eff_len);
  assign a_byte   = step.in_frame ? step.data : 8'h00;
  assign b_byte   = prefix[{step.idx, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      result <= 1'b1;
    end else if (clear) begin
      done   <= 1'b0;
      result <= 1'b1;
    end else if (step.valid && !done && in_range) begin
      if (a_byte != b_byte) begin
        done   <= 1'b1;
        result <= 1'b0;
      end else if (a_byte == 8'h00 || !step.in_frame) begin
        done   <= 1'b1;
        result <= 1'b1;
      end
    end
  end

  // undecided after all positions counts as a match
  assign match = !done || result;

endmodule
